// ===== rtl/cumulative_weight_sampler_assert.svh =====
// Assertion macros for the cumulative weight sampler.
// Expects i_clk and i_rst_n in the scope of use; no other dependencies.
`ifndef CUMULATIVE_WEIGHT_SAMPLER_ASSERT_SVH
`define CUMULATIVE_WEIGHT_SAMPLER_ASSERT_SVH

// same-cycle implication
`define CWS_ASSERT_IMPL(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication
`define CWS_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== rtl/cws_pkg.sv =====
// Shared constants and types for the cumulative weight sampler.
// No dependencies.
`default_nettype none

package cws_pkg;

    localparam int FRAC_W     = 16;
    localparam int WEIGHT_W   = 16;
    localparam int OUT_IDX_W  = 10;

    typedef struct packed {
        logic busy;
        logic done;
    } t_srch_stat;

endpackage

`default_nettype wire

// ===== rtl/cws_if.sv =====
// Request and result channel interfaces of the cumulative weight sampler.
// Depends on cws_pkg.
`default_nettype none

interface cws_in_if import cws_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                action;
    logic                first_weight;
    logic [WEIGHT_W-1:0] weight;
    logic [FRAC_W-1:0]   uniform_value;

    modport source (output valid, action, first_weight, weight, uniform_value, input ready);
    modport sink   (input valid, action, first_weight, weight, uniform_value, output ready);
endinterface

interface cws_out_if import cws_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [OUT_IDX_W-1:0] sample_index;
    logic                 draw_error;

    modport source (output valid, sample_index, draw_error, input ready);
    modport sink   (input valid, sample_index, draw_error, output ready);
endinterface

`default_nettype wire

// ===== rtl/cws_table.sv =====
// Cumulative sum table: one write port, one read port with registered data.
// No package dependencies.
`default_nettype none

module cws_table #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 26
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/cws_search.sv =====
// Binary search sequencer over the cumulative table: one compare per step.
// Depends on cws_pkg; drives the read port of cws_table.
`default_nettype none

module cws_search import cws_pkg::*; #(
    parameter int DEPTH = 1024,
    parameter int CUM_W = 26
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [FRAC_W-1:0]          i_uniform,
    input  wire logic [CUM_W-1:0]           i_total,
    input  wire logic [$clog2(DEPTH+1)-1:0] i_count,
    output logic      [$clog2(DEPTH)-1:0]   o_rd_addr,
    input  wire logic [CUM_W-1:0]           i_rd_data,
    output t_srch_stat                      o_stat,
    output logic      [OUT_IDX_W-1:0]       o_index
);

    localparam int CNT_W  = $clog2(DEPTH+1);
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int PROD_W = CUM_W + FRAC_W;

    typedef enum logic [1:0] {SS_IDLE, SS_READ, SS_CMP} t_sstate;

    t_sstate               r_state;
    logic                  r_done;
    logic [PROD_W-1:0]     r_target;
    logic [CNT_W-1:0]      r_lo;
    logic [CNT_W-1:0]      r_hi;
    logic [CNT_W-1:0]      r_mid;
    logic [CNT_W-1:0]      r_cnt;
    logic [OUT_IDX_W-1:0]  r_index;

    logic [PROD_W-1:0]          w_prod;
    logic [CNT_W-1:0]           w_mid;
    logic                       w_hit;
    logic [CNT_W-1:0]           w_last;
    logic [CNT_W+OUT_IDX_W-1:0] w_last_ext;

    assign w_prod     = i_uniform * i_total;
    assign w_mid      = r_lo + ((r_hi - r_lo) >> 1);
    assign o_rd_addr  = w_mid[IDX_W-1:0];
    assign w_hit      = {i_rd_data, FRAC_W'(0)} >= r_target;
    // clamp to the last entry when no entry reaches the target
    assign w_last     = (r_lo == r_cnt) ? r_cnt - CNT_W'(1) : r_lo;
    assign w_last_ext = (CNT_W+OUT_IDX_W)'(w_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == SS_READ) && !(r_lo < r_hi);
            case (r_state)
                SS_IDLE: begin
                    if (i_start) begin
                        r_target <= w_prod;
                        r_lo     <= '0;
                        r_hi     <= i_count;
                        r_cnt    <= i_count;
                        r_state  <= SS_READ;
                    end
                end
                SS_READ: begin
                    if (r_lo < r_hi) begin
                        r_mid   <= w_mid;
                        r_state <= SS_CMP;
                    end else begin
                        r_index <= w_last_ext[OUT_IDX_W-1:0];
                        r_state <= SS_IDLE;
                    end
                end
                SS_CMP: begin
                    if (w_hit) begin
                        r_hi <= r_mid;
                    end else begin
                        r_lo <= r_mid + CNT_W'(1);
                    end
                    r_state <= SS_READ;
                end
                default: begin
                    r_state <= SS_IDLE;
                end
            endcase
        end
    end

    assign o_stat.busy = (r_state != SS_IDLE);
    assign o_stat.done = r_done;
    assign o_index     = r_index;

endmodule

`default_nettype wire

// ===== rtl/cumulative_weight_sampler.sv =====
// Cumulative weight sampler: builds a running-sum table from load requests
// and answers draw requests by inverse-CDF lookup. A load is taken every
// cycle while no draw is in progress; a draw holds the request side for its
// whole binary search, each search step a table read and then a compare,
// set by the single read port of the table memory and its registered read,
// and for as long as a previous result still occupies the output register.
// A draw on an empty table or a zero total answers without a search, with
// draw_error set. A finished result waits in an output register while loads
// continue. Depends on cws_pkg, cws_if, cws_table, cws_search.
`default_nettype none
`include "cumulative_weight_sampler_assert.svh"

module cumulative_weight_sampler import cws_pkg::*; #(
    parameter int DEPTH       = 1024,
    parameter int WEIGHT_BITS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cws_in_if.sink    i_req,
    cws_out_if.source o_rsp
);

    localparam int WB_EFF = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;
    localparam int CUM_W  = WB_EFF + $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH+1);
    localparam int IDX_W  = $clog2(DEPTH);

    typedef enum logic [1:0] {ST_IDLE, ST_SEARCH, ST_PEND} t_state;

    t_state               r_state;
    logic [CNT_W-1:0]     r_count;
    logic [CUM_W-1:0]     r_total;
    logic [OUT_IDX_W-1:0] r_res_idx;
    logic                 r_res_err;
    logic                 r_out_valid;
    logic [OUT_IDX_W-1:0] r_out_idx;
    logic                 r_out_err;

    logic                 w_acc;
    logic [CNT_W-1:0]     w_base_cnt;
    logic [CUM_W-1:0]     w_base_tot;
    logic                 w_load_ok;
    logic [CUM_W-1:0]     w_sum;
    logic                 w_wr_en;
    logic                 w_empty;
    logic                 w_start;
    logic [IDX_W-1:0]     w_rd_addr;
    logic [CUM_W-1:0]     w_rd_data;
    t_srch_stat           w_stat;
    logic [OUT_IDX_W-1:0] w_index;

    assign i_req.ready = (r_state == ST_IDLE);
    assign w_acc       = i_req.valid && i_req.ready;

    always_comb begin
        w_base_cnt = i_req.first_weight ? '0 : r_count;
        w_base_tot = i_req.first_weight ? '0 : r_total;
        w_load_ok  = (w_base_cnt < CNT_W'(DEPTH));
        w_sum      = w_base_tot + CUM_W'(i_req.weight[WB_EFF-1:0]);
    end

    assign w_wr_en = w_acc && !i_req.action && w_load_ok;
    assign w_empty = (r_count == '0) || (r_total == '0);
    assign w_start = w_acc && i_req.action && !w_empty;

    cws_table #(
        .DEPTH (DEPTH),
        .WIDTH (CUM_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_base_cnt[IDX_W-1:0]),
        .i_wr_data (w_sum),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    cws_search #(
        .DEPTH (DEPTH),
        .CUM_W (CUM_W)
    ) u_search (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start),
        .i_uniform (i_req.uniform_value),
        .i_total   (r_total),
        .i_count   (r_count),
        .o_rd_addr (w_rd_addr),
        .i_rd_data (w_rd_data),
        .o_stat    (w_stat),
        .o_index   (w_index)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_rsp.ready && (r_state != ST_PEND)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_acc && !i_req.action) begin
                        if (w_load_ok) begin
                            r_count <= w_base_cnt + CNT_W'(1);
                            r_total <= w_sum;
                        end
                    end else if (w_acc) begin
                        if (w_empty) begin
                            r_res_idx <= '0;
                            r_res_err <= 1'b1;
                            r_state   <= ST_PEND;
                        end else begin
                            r_state <= ST_SEARCH;
                        end
                    end
                end
                ST_SEARCH: begin
                    if (w_stat.done) begin
                        r_res_idx <= w_index;
                        r_res_err <= 1'b0;
                        r_state   <= ST_PEND;
                    end
                end
                ST_PEND: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_idx   <= r_res_idx;
                        r_out_err   <= r_res_err;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.sample_index = r_out_idx;
    assign o_rsp.draw_error   = r_out_err;

    `CWS_ASSERT_IMPL(a_count_bound, 1'b1, r_count <= CNT_W'(DEPTH), "entry count above depth")
    `CWS_ASSERT_IMPL(a_busy_in_search, w_stat.busy, r_state == ST_SEARCH, "search busy outside search")
    `CWS_ASSERT_IMPL(a_done_in_search, w_stat.done, r_state == ST_SEARCH, "search done unexpected")
    `CWS_ASSERT_NEXT(a_draw_leaves_idle, w_acc && i_req.action, r_state != ST_IDLE, "draw not started")

endmodule

`default_nettype wire

// ===== tb/sv/cumulative_weight_sampler_test.sv =====
// Self-checking test of cumulative_weight_sampler: loads weight tables, draws samples and
// compares each answer against an in-bench cumulative-sum table and lower-bound search.
// Depends on cws_pkg, cws_if and the cumulative_weight_sampler RTL.
`default_nettype none

module cumulative_weight_sampler_test;
    import cws_pkg::*;

    localparam int TABLE_DEPTH  = 1024;
    localparam int RANDOM_ITEMS = 190;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 64;

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_DRAW = 1'b1
    } sampler_action_e;

    typedef struct packed {
        sampler_action_e     action;
        logic                first_weight;
        logic [WEIGHT_W-1:0] weight;
        logic [FRAC_W-1:0]   uniform_value;
    } sampler_req_t;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] sample_index;
        logic                 draw_error;
    } sample_result_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cws_in_if  req_bus ();
    cws_out_if rsp_bus ();

    cumulative_weight_sampler #(
        .DEPTH       (TABLE_DEPTH),
        .WEIGHT_BITS (WEIGHT_W)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    sampler_req_t      pending_reqs [$];
    sample_result_t    expected_samples [$];
    longint unsigned   cum_table [TABLE_DEPTH];
    int unsigned       entry_count;
    longint unsigned   weight_total;
    int unsigned       mismatch_count;
    int unsigned       cycle_count;
    int unsigned       queued_items;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Table update on load; on draw, lowest index with cum*2^16 >= u*total (else the last entry), or error if empty.
    task automatic predict_sample(input sampler_req_t req);
        longint unsigned target;
        int unsigned     lo;
        int unsigned     hi;
        int unsigned     mid;
        sample_result_t  res;
        if (req.action == ACT_LOAD) begin
            if (req.first_weight) begin
                entry_count  = 0;
                weight_total = 0;
            end
            if (entry_count < TABLE_DEPTH) begin
                weight_total += req.weight;
                cum_table[entry_count] = weight_total;
                entry_count++;
            end
        end else begin
            if (entry_count == 0 || weight_total == 0) begin
                res.sample_index = '0;
                res.draw_error   = 1'b1;
            end else begin
                target = longint'(req.uniform_value) * weight_total;
                lo = 0;
                hi = entry_count;
                while (lo < hi) begin
                    mid = lo + (hi - lo) / 2;
                    if ((cum_table[mid] << FRAC_W) >= target)
                        hi = mid;
                    else
                        lo = mid + 1;
                end
                if (lo >= entry_count)
                    lo = entry_count - 1;
                res.sample_index = lo[OUT_IDX_W-1:0];
                res.draw_error   = 1'b0;
            end
            expected_samples = {expected_samples, res};
        end
    endtask

    // request driver
    sampler_req_t cur_req;
    int           req_gap;
    bit           req_burst;

    always @(posedge i_clk) begin : req_driver
        logic send_valid;
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
            req_gap   = 0;
            req_burst = 1'b0;
        end else begin
            send_valid = req_bus.valid;
            if (req_bus.valid && req_bus.ready) begin
                predict_sample(cur_req);
                if ($urandom_range(0, 63) == 0)
                    req_burst = !req_burst;
                req_gap = req_burst ? 0 : $urandom_range(0, 9);
            end
            if (!(req_bus.valid && !req_bus.ready)) begin
                if (req_gap > 0) begin
                    req_gap--;
                    send_valid = 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    cur_req = pending_reqs.pop_front();
                    req_bus.action        <= cur_req.action;
                    req_bus.first_weight  <= cur_req.first_weight;
                    req_bus.weight        <= cur_req.weight;
                    req_bus.uniform_value <= cur_req.uniform_value;
                    send_valid = 1'b1;
                end else begin
                    send_valid = 1'b0;
                end
            end
            req_bus.valid <= send_valid;
        end
    end

    // result monitor
    int rsp_stall;
    bit rsp_burst;

    always @(posedge i_clk) begin : rsp_monitor
        sample_result_t want;
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
            rsp_stall = 0;
            rsp_burst = 1'b0;
        end else begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                if (expected_samples.size() == 0) begin
                    report_mismatch($sformatf("unexpected result index %0d error %0b",
                                              rsp_bus.sample_index, rsp_bus.draw_error));
                end else begin
                    want = expected_samples.pop_front();
                    if (rsp_bus.sample_index !== want.sample_index)
                        report_mismatch($sformatf("sample_index %0d, want %0d",
                                                  rsp_bus.sample_index, want.sample_index));
                    if (rsp_bus.draw_error !== want.draw_error)
                        report_mismatch($sformatf("draw_error %0b, want %0b",
                                                  rsp_bus.draw_error, want.draw_error));
                end
                if ($urandom_range(0, 63) == 0)
                    rsp_burst = !rsp_burst;
                rsp_stall = rsp_burst ? 0 : $urandom_range(0, 9);
            end else if (rsp_stall > 0) begin
                rsp_stall--;
            end
            rsp_bus.ready <= (rsp_stall == 0);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic queue_req(input sampler_action_e act, input logic first,
                             input logic [WEIGHT_W-1:0] w, input logic [FRAC_W-1:0] u);
        sampler_req_t req;
        req.action        = act;
        req.first_weight  = first;
        req.weight        = w;
        req.uniform_value = u;
        pending_reqs = {pending_reqs, req};
        queued_items++;
    endtask

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return WEIGHT_W'($urandom_range(0, 3));
            default: return WEIGHT_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [FRAC_W-1:0] pick_fraction();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return FRAC_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [15:0] noise16();
        return 16'($urandom_range(0, 65535));
    endfunction

    initial begin
        int unsigned start_count;
        int unsigned n_loads;
        int unsigned n_draws;
        int unsigned kind;

        i_rst_n               = 1'b0;
        req_bus.valid         = 1'b0;
        req_bus.action        = ACT_LOAD;
        req_bus.first_weight  = 1'b0;
        req_bus.weight        = '0;
        req_bus.uniform_value = '0;
        rsp_bus.ready         = 1'b0;
        cycle_count           = 0;
        mismatch_count        = 0;
        queued_items          = 0;
        entry_count           = 0;
        weight_total          = 0;

        // empty table, zero totals, extremes of u and weight
        queue_req(ACT_DRAW, 1'b1, 16'hFFFF, 16'hFFFF);
        queue_req(ACT_LOAD, 1'b1, 16'h0000, 16'hFFFF);
        queue_req(ACT_DRAW, 1'b0, 16'hFFFF, 16'h0000);
        queue_req(ACT_LOAD, 1'b0, 16'h0000, 16'h1234);
        queue_req(ACT_DRAW, 1'b1, 16'h5A5A, 16'hFFFF);
        queue_req(ACT_LOAD, 1'b1, 16'hFFFF, 16'hA5A5);
        queue_req(ACT_LOAD, 1'b0, 16'h0000, 16'h0000);
        queue_req(ACT_LOAD, 1'b0, 16'hFFFF, 16'hFFFF);
        queue_req(ACT_LOAD, 1'b0, 16'h0001, 16'h0000);
        queue_req(ACT_DRAW, 1'b0, 16'h0000, 16'h0000);
        queue_req(ACT_DRAW, 1'b1, 16'hFFFF, 16'hFFFF);
        queue_req(ACT_DRAW, 1'b0, 16'h0000, 16'h8000);
        queue_req(ACT_DRAW, 1'b0, 16'h0000, 16'h7FFF);
        queue_req(ACT_DRAW, 1'b0, 16'h0000, 16'h8001);
        queue_req(ACT_LOAD, 1'b1, 16'h0001, 16'h0000);
        queue_req(ACT_LOAD, 1'b0, 16'h0000, 16'h0000);
        queue_req(ACT_LOAD, 1'b0, 16'h0001, 16'h0000);
        queue_req(ACT_DRAW, 1'b0, 16'h0000, 16'h8000);
        queue_req(ACT_DRAW, 1'b0, 16'h0000, 16'h8001);
        queue_req(ACT_DRAW, 1'b0, 16'h0000, 16'h0001);

        // fill past capacity, then restart the table while full
        queue_req(ACT_LOAD, 1'b1, pick_weight(), noise16());
        repeat (TABLE_DEPTH + 5)
            queue_req(ACT_LOAD, 1'b0, pick_weight(), noise16());
        queue_req(ACT_DRAW, 1'b0, noise16(), 16'h0000);
        queue_req(ACT_DRAW, 1'b1, noise16(), 16'hFFFF);
        repeat (4)
            queue_req(ACT_DRAW, 1'($urandom_range(0, 1)), noise16(), noise16());
        queue_req(ACT_LOAD, 1'b1, 16'h1234, noise16());
        queue_req(ACT_DRAW, 1'b0, noise16(), noise16());
        queue_req(ACT_LOAD, 1'b0, noise16(), noise16());
        queue_req(ACT_DRAW, 1'b0, noise16(), pick_fraction());

        start_count = queued_items;
        while (queued_items - start_count < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 9);
            if (kind == 9) begin
                repeat ($urandom_range(1, 5))
                    queue_req(sampler_action_e'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), noise16(), noise16());
            end else begin
                n_loads = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 300)
                                                      : $urandom_range(0, 15);
                if (kind <= 6)
                    queue_req(ACT_LOAD, 1'b1, pick_weight(), noise16());
                repeat (n_loads)
                    queue_req(ACT_LOAD, 1'b0, pick_weight(), noise16());
                n_draws = $urandom_range(1, 6);
                repeat (n_draws)
                    queue_req(ACT_DRAW, 1'($urandom_range(0, 1)), noise16(), pick_fraction());
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || req_bus.valid || expected_samples.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== cumulative_weight_sampler.f =====
+incdir+rtl
rtl/cws_pkg.sv
rtl/cws_if.sv
rtl/cws_table.sv
rtl/cws_search.sv
rtl/cumulative_weight_sampler.sv
tb/sv/cumulative_weight_sampler_test.sv
